// ----- src/cljcf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cljcf_pkg
// shared types and constants of the capped lennard-jones contact force block
// ----------------------------------------------------------------------------
package cljcf_pkg;

	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_SQ = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FORCE_CAP = 2'd1;

	localparam logic [31:0] CUTOFF_SQ_RESET = 32'd21233664;
	localparam logic [31:0] FORCE_CAP_RESET = 32'hFFFF_FFFF;

	// saturation level of every intermediate magnitude
	localparam logic [63:0] MAG_LIM       = 64'h4000_0000_0000_0000;
	localparam logic [63:0] MAG_LIM_DIV24 = MAG_LIM / 24;

	// per-contact context riding along the pipeline
	typedef struct packed {
		logic [2:0][31:0] mag;
		logic [2:0]       neg;
		logic             in_range;
		logic             eneg;
		logic             fneg;
		logic             ovf;
		logic [31:0]      r;
		logic [31:0]      energy;
		logic [63:0]      a;
		logic [63:0]      b;
		logic [63:0]      c;
	} ctx_t;

endpackage

// ----- src/capped_lj_contact_force.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capped_lj_contact_force
// lennard-jones 12-6 contact force and energy with cutoff and force cap
// ----------------------------------------------------------------------------
// throughput: one transaction per cycle unless stalled, set by the bit-per-stage
//   square root and the three bit-per-stage dividers, all fully pipelined
// a stalled result freezes the whole pipeline, nothing is dropped or repeated
// reset clears all valid bits and loads the register defaults
// ----------------------------------------------------------------------------
module capped_lj_contact_force #(
	parameter int FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// contact transaction
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic signed [31:0]                 first_x,
	input  logic signed [31:0]                 first_y,
	input  logic signed [31:0]                 first_z,
	input  logic signed [31:0]                 second_x,
	input  logic signed [31:0]                 second_y,
	input  logic signed [31:0]                 second_z,
	input  logic        [31:0]                 sig2,
	// result transaction
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic signed [31:0]                 force_x,
	output logic signed [31:0]                 force_y,
	output logic signed [31:0]                 force_z,
	output logic signed [31:0]                 pair_energy,
	output logic                               in_range,
	// register writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [cljcf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                        cfg_data
);

	import cljcf_pkg::*;

	localparam int XW     = 32 + FRAC_BITS;     // width of d2 << frac
	localparam int SQ_N   = (XW + 1) / 2;       // square root stages / root bits
	localparam int XPW    = 2 * SQ_N;
	localparam int RW     = SQ_N + 2;
	localparam int NW     = 32 + FRAC_BITS;     // divider numerator / quotient
	localparam int SIDE_W = $bits(ctx_t);
	localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;

	// --- helpers ----------------------------------------------------------

	// four 32x32 partial products of two magnitudes below 2^63
	function automatic logic [3:0][63:0] pp4(input logic [63:0] x, input logic [63:0] y);
		pp4[0] = {32'd0, x[31:0]}  * {32'd0, y[31:0]};
		pp4[1] = {32'd0, x[31:0]}  * {32'd0, y[63:32]};
		pp4[2] = {32'd0, x[63:32]} * {32'd0, y[31:0]};
		pp4[3] = {32'd0, x[63:32]} * {32'd0, y[63:32]};
	endfunction

	function automatic logic [127:0] ppsum(input logic [3:0][63:0] p);
		ppsum = {64'd0, p[0]} + ({64'd0, p[1]} << 32) + ({64'd0, p[2]} << 32)
			+ {p[3], 64'd0};
	endfunction

	// fixed point rescale with saturation
	function automatic logic [63:0] qsat(input logic [127:0] s);
		logic [127:0] sh;
		sh = s >> FRAC_BITS;
		qsat = (sh > {64'd0, MAG_LIM}) ? MAG_LIM : sh[63:0];
	endfunction

	function automatic logic [31:0] sat_out(input logic neg, input logic [63:0] mag);
		logic [63:0] m;
		if (neg) begin
			m = (mag > 64'h8000_0000) ? 64'h8000_0000 : mag;
			sat_out = 32'(64'd0 - m);
		end else begin
			sat_out = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
		end
	endfunction

	// --- configuration ----------------------------------------------------

	logic [31:0] cutoff_sq_q;
	logic [31:0] force_cap_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_sq_q <= CUTOFF_SQ_RESET;
			force_cap_q <= FORCE_CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_CUTOFF_SQ) cutoff_sq_q <= cfg_data;
			if (cfg_index == CFG_FORCE_CAP) force_cap_q <= cfg_data;
		end
	end

	// --- flow control -----------------------------------------------------

	// whole pipeline moves unless the output register holds a stalled result
	logic adv;
	assign adv        = !result_valid || !result_stall;
	assign item_stall = !adv;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic v_s11, v_s12, v_s13, v_s14, v_s15, v_s16, v_s17, v_s18, v_s19, v_s20;
	logic ds_v, dq_v, dg_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10} <= '0;
			{v_s11, v_s12, v_s13, v_s14, v_s15, v_s16, v_s17, v_s18, v_s19, v_s20} <= '0;
		end else if (adv) begin
			v_s1  <= item_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= ds_v;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			v_s15 <= v_s14;
			v_s16 <= dq_v;
			v_s17 <= dg_v;
			v_s18 <= v_s17;
			v_s19 <= v_s18;
			v_s20 <= v_s19;
		end
	end

	// --- s1: separation vector, sign and magnitude per axis ---------------

	logic [2:0][31:0] fa, sa;
	ctx_t             c1;

	assign fa = {first_z, first_y, first_x};
	assign sa = {second_z, second_y, second_x};

	always_comb begin
		logic [32:0] d;
		c1 = '0;
		for (int i = 0; i < 3; i++) begin
			d = {sa[i][31], sa[i]} - {fa[i][31], fa[i]};
			c1.neg[i] = d[32];
			c1.mag[i] = d[32] ? 32'(33'd0 - d) : d[31:0];
		end
		c1.b = {32'd0, sig2};
	end

	ctx_t ctx_s1, ctx_s2, ctx_s3;
	logic [63:0] sq_s2 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s1 <= c1;
			// s2: squared components
			ctx_s2 <= ctx_s1;
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= {32'd0, ctx_s1.mag[i]} * {32'd0, ctx_s1.mag[i]};
			end
		end
	end

	// --- s3: squared distance and cutoff test -----------------------------

	logic [65:0] sum3, d2w3;
	logic        inr3;
	ctx_t        c3;

	assign sum3 = {2'd0, sq_s2[0]} + {2'd0, sq_s2[1]} + {2'd0, sq_s2[2]};
	assign d2w3 = sum3 >> FRAC_BITS;
	assign inr3 = d2w3 <= {34'd0, cutoff_sq_q};

	always_comb begin
		c3          = ctx_s2;
		c3.in_range = inr3;
		// coincident atoms raise d2 to one lsb; skipped contacts use one too
		c3.a        = (!inr3 || d2w3 == '0) ? 64'd1 : {32'd0, d2w3[31:0]};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s3 <= c3;
		end
	end

	// --- square root of d2 << frac, one root bit per stage ----------------

	logic [XPW-1:0]  sqx_s    [SQ_N];
	logic [RW-1:0]   sqrem_s  [SQ_N];
	logic [SQ_N-1:0] sqroot_s [SQ_N];
	ctx_t            sqctx_s  [SQ_N];
	logic [SQ_N-1:0] sqv_s;

	for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
		logic [XPW-1:0]  xi;
		logic [RW-1:0]   ri;
		logic [SQ_N-1:0] oi;
		ctx_t            ci;
		logic            vi;
		logic [RW+1:0]   ext;
		logic [RW+1:0]   trial;
		logic            ge;

		if (k == 0) begin : g_first
			assign xi = XPW'({ctx_s3.a[31:0], {FRAC_BITS{1'b0}}});
			assign ri = '0;
			assign oi = '0;
			assign ci = ctx_s3;
			assign vi = v_s3;
		end else begin : g_next
			assign xi = sqx_s[k-1];
			assign ri = sqrem_s[k-1];
			assign oi = sqroot_s[k-1];
			assign ci = sqctx_s[k-1];
			assign vi = sqv_s[k-1];
		end

		assign ext   = {ri, xi[XPW-1 -: 2]};
		assign trial = (RW + 2)'({oi, 2'b01});
		assign ge    = ext >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sqv_s[k] <= 1'b0;
			end else if (adv) begin
				sqv_s[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sqx_s[k]    <= xi << 2;
				sqrem_s[k]  <= ge ? RW'(ext - trial) : RW'(ext);
				sqroot_s[k] <= {oi[SQ_N-2:0], ge};
				sqctx_s[k]  <= ci;
			end
		end
	end

	ctx_t sq_ctx;

	always_comb begin
		sq_ctx   = sqctx_s[SQ_N-1];
		sq_ctx.r = 32'(sqroot_s[SQ_N-1]);
	end

	// --- s = sigma squared / d2 -------------------------------------------

	logic [NW-1:0]     ds_quot;
	logic [SIDE_W-1:0] ds_side;
	ctx_t              ds_ctx;

	cljcf_div #(
		.NW     (NW),
		.DW     (32),
		.SIDE_W (SIDE_W)
	) u_div_s (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (sqv_s[SQ_N-1]),
		.in_rem    (32'd0),
		.in_num    ({sq_ctx.b[31:0], {FRAC_BITS{1'b0}}}),
		.in_den    (sq_ctx.a[31:0]),
		.in_side   (sq_ctx),
		.out_valid (ds_v),
		.out_quot  (ds_quot),
		.out_side  (ds_side)
	);

	always_comb begin
		ds_ctx   = ctx_t'(ds_side);
		ds_ctx.a = 64'(ds_quot);
	end

	// --- s4..s9: s6 = (s*s)*s ---------------------------------------------

	ctx_t ctx_s4, ctx_s5, ctx_s6, ctx_s7, ctx_s8, ctx_s9, ctx_s10;
	logic [3:0][63:0] pp1_s4, pp2_s7;
	logic [127:0]     sum1_s5, sum2_s8;
	ctx_t             c6, c9;

	always_comb begin
		c6   = ctx_s5;
		c6.b = qsat(sum1_s5);
		c9   = ctx_s8;
		c9.a = qsat(sum2_s8);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s4    <= ds_ctx;
			pp1_s4    <= pp4(ds_ctx.a, ds_ctx.a);
			ctx_s5    <= ctx_s4;
			sum1_s5   <= ppsum(pp1_s4);
			ctx_s6    <= c6;
			ctx_s7    <= ctx_s6;
			pp2_s7    <= pp4(ctx_s6.b, ctx_s6.a);
			ctx_s8    <= ctx_s7;
			sum2_s8   <= ppsum(pp2_s7);
			ctx_s9    <= c9;
		end
	end

	// --- s10: factors of the energy and force terms -----------------------

	logic [63:0] t10;
	logic        eneg10, fneg10;
	ctx_t        c10;

	assign t10    = (ctx_s9.a > (MAG_LIM >> 1)) ? MAG_LIM : (ctx_s9.a << 1);
	assign eneg10 = ctx_s9.a < ONE;
	assign fneg10 = t10 >= ONE;

	always_comb begin
		c10      = ctx_s9;
		c10.eneg = eneg10;
		c10.fneg = fneg10;
		c10.b    = eneg10 ? (ONE - ctx_s9.a) : (ctx_s9.a - ONE);
		c10.c    = fneg10 ? (t10 - ONE) : (ONE - t10);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s10 <= c10;
		end
	end

	// --- s11..s15: energy and unscaled force ------------------------------

	ctx_t ctx_s11, ctx_s12, ctx_s13, ctx_s14, ctx_s15;
	logic [3:0][63:0] ppe_s11, ppf_s11;
	logic [127:0]     sume_s12, sumf_s12;
	ctx_t             c13, c14, c15;

	always_comb begin
		c13   = ctx_s12;
		c13.b = qsat(sume_s12);
		c13.c = qsat(sumf_s12);
		// saturating scale by 4 and by 24
		c14   = ctx_s13;
		c14.b = (ctx_s13.b > (MAG_LIM >> 2)) ? MAG_LIM : (ctx_s13.b << 2);
		c14.c = (ctx_s13.c > MAG_LIM_DIV24) ? MAG_LIM
			: ((ctx_s13.c << 4) + (ctx_s13.c << 3));
		// quotient m / r beyond 32 integer bits falls back to the cap
		c15        = ctx_s14;
		c15.ovf    = ctx_s14.c >= {ctx_s14.r, 32'd0};
		c15.energy = sat_out(ctx_s14.eneg && ctx_s14.b != '0, ctx_s14.b);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s11   <= ctx_s10;
			ppe_s11   <= pp4(ctx_s10.a, ctx_s10.b);
			ppf_s11   <= pp4(ctx_s10.a, ctx_s10.c);
			ctx_s12   <= ctx_s11;
			sume_s12  <= ppsum(ppe_s11);
			sumf_s12  <= ppsum(ppf_s11);
			ctx_s13   <= c13;
			ctx_s14   <= c14;
			ctx_s15   <= c15;
		end
	end

	// --- q = m << frac / r, high part of m preloads the remainder ---------

	logic [31:0]       dq_rem;
	logic [NW-1:0]     dq_quot;
	logic [SIDE_W-1:0] dq_side;
	ctx_t              dq_ctx;

	assign dq_rem = ctx_s15.ovf ? 32'd0 : ctx_s15.c[63:32];

	cljcf_div #(
		.NW     (NW),
		.DW     (32),
		.SIDE_W (SIDE_W)
	) u_div_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s15),
		.in_rem    (dq_rem),
		.in_num    ({ctx_s15.c[31:0], {FRAC_BITS{1'b0}}}),
		.in_den    (ctx_s15.r),
		.in_side   (ctx_s15),
		.out_valid (dq_v),
		.out_quot  (dq_quot),
		.out_side  (dq_side)
	);

	// --- s16: clamp to force cap ------------------------------------------

	logic [NW-1:0] q16;
	ctx_t          ctx_s16;
	ctx_t          c16;

	assign dq_ctx = ctx_t'(dq_side);
	assign q16    = dq_ctx.ovf ? NW'(force_cap_q) : dq_quot;

	always_comb begin
		c16   = dq_ctx;
		c16.c = {32'd0, (q16 > NW'(force_cap_q)) ? force_cap_q : q16[31:0]};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s16 <= c16;
		end
	end

	// --- g = q << frac / r ------------------------------------------------

	logic [NW-1:0]     dg_quot;
	logic [SIDE_W-1:0] dg_side;
	ctx_t              dg_ctx;

	cljcf_div #(
		.NW     (NW),
		.DW     (32),
		.SIDE_W (SIDE_W)
	) u_div_g (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s16),
		.in_rem    (32'd0),
		.in_num    ({ctx_s16.c[31:0], {FRAC_BITS{1'b0}}}),
		.in_den    (ctx_s16.r),
		.in_side   (ctx_s16),
		.out_valid (dg_v),
		.out_quot  (dg_quot),
		.out_side  (dg_side)
	);

	always_comb begin
		dg_ctx   = ctx_t'(dg_side);
		dg_ctx.c = 64'(dg_quot);
	end

	// --- s17..s19: per-axis force magnitude |v_i| * g ---------------------

	ctx_t ctx_s17, ctx_s18, ctx_s19;
	logic [3:0][63:0] pp4_s17  [3];
	logic [127:0]     sum4_s18 [3];
	logic [63:0]      c4_s19   [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s17 <= dg_ctx;
			ctx_s18 <= ctx_s17;
			ctx_s19 <= ctx_s18;
			for (int i = 0; i < 3; i++) begin
				pp4_s17[i]  <= pp4({32'd0, dg_ctx.mag[i]}, dg_ctx.c);
				sum4_s18[i] <= ppsum(pp4_s17[i]);
				c4_s19[i]   <= qsat(sum4_s18[i]);
			end
		end
	end

	// --- s20: signed outputs, skipped contacts read zero ------------------

	logic [31:0] fo_s20 [3];
	logic [31:0] e_s20;
	logic        inr_s20;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				fo_s20[i] <= ctx_s19.in_range
					? sat_out((ctx_s19.neg[i] != ctx_s19.fneg) && c4_s19[i] != '0, c4_s19[i])
					: 32'd0;
			end
			e_s20   <= ctx_s19.in_range ? ctx_s19.energy : 32'd0;
			inr_s20 <= ctx_s19.in_range;
		end
	end

	assign result_valid = v_s20;
	assign force_x      = fo_s20[0];
	assign force_y      = fo_s20[1];
	assign force_z      = fo_s20[2];
	assign pair_energy  = e_s20;
	assign in_range     = inr_s20;

	// --- assertions -------------------------------------------------------

	// a contact beyond the cutoff leaves only zeros
	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !in_range |->
			force_x == 32'sd0 && force_y == 32'sd0 && force_z == 32'sd0
			&& pair_energy == 32'sd0)
		else $error("skipped contact with nonzero outputs");

	// preloaded remainder of the force divider must stay below r
	a_div_pre: assert property (@(posedge clk) disable iff (!arst_n)
		v_s15 |-> dq_rem < ctx_s15.r)
		else $error("force divider remainder preload not below r");

	// scalar force never exceeds the cap it was clamped against
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		$past(adv) && v_s16 |-> ctx_s16.c <= {32'd0, $past(force_cap_q)})
		else $error("scalar force above cap");

endmodule

// ----- src/cljcf_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cljcf_div
// pipelined restoring divider, one quotient bit per stage, with side payload
// ----------------------------------------------------------------------------
module cljcf_div #(
	parameter int NW     = 48,
	parameter int DW     = 32,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [DW-1:0]     in_rem,
	input  logic [NW-1:0]     in_num,
	input  logic [DW-1:0]     in_den,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [NW-1:0]     out_quot,
	output logic [SIDE_W-1:0] out_side
);

	logic [DW-1:0]     rem_s  [NW];
	logic [NW-1:0]     num_s  [NW];
	logic [DW-1:0]     den_s  [NW];
	logic [SIDE_W-1:0] side_s [NW];
	logic [NW-1:0]     v_s;

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [DW-1:0]     ri;
		logic [NW-1:0]     ni;
		logic [DW-1:0]     di;
		logic [SIDE_W-1:0] si;
		logic              vi;
		logic [DW:0]       ext;
		logic              ge;

		if (k == 0) begin : g_first
			assign ri = in_rem;
			assign ni = in_num;
			assign di = in_den;
			assign si = in_side;
			assign vi = in_valid;
		end else begin : g_next
			assign ri = rem_s[k-1];
			assign ni = num_s[k-1];
			assign di = den_s[k-1];
			assign si = side_s[k-1];
			assign vi = v_s[k-1];
		end

		// remainder stays below the divisor, so the trial fits one extra bit
		assign ext = {ri, ni[NW-1]};
		assign ge  = ext >= {1'b0, di};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? DW'(ext - {1'b0, di}) : DW'(ext);
				num_s[k]  <= {ni[NW-2:0], ge};
				den_s[k]  <= di;
				side_s[k] <= si;
			end
		end
	end

	assign out_valid = v_s[NW-1];
	assign out_quot  = num_s[NW-1];
	assign out_side  = side_s[NW-1];

endmodule

// ----- dv/capped_lj_contact_force_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capped_lj_contact_force_tb
// self-checking bench: streams contacts through the force block under random
// input gaps and output stalls, predicts every result in a bit-exact
// fixed-point model and compares each field; sweeps cutoff and force cap
// ----------------------------------------------------------------------------
module capped_lj_contact_force_tb;
	import cljcf_pkg::*;

	localparam int FB = 16;
	localparam logic [63:0] ONE_Q = 64'd1 << FB;
	localparam logic [63:0] M32 = 64'hFFFF_FFFF;
	// indexes past the two registers, writes there must do nothing
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
	localparam int DRAIN_CYCLES = 220;

	typedef struct {
		logic [31:0] ax, ay, az, bx, by, bz, sig;
	} contact_t;

	typedef struct {
		logic [31:0] fx, fy, fz, en;
		logic        hit;
	} force_t;

	// ------------------------------------------------------------------
	// contact force scoreboard: register copies plus expected results
	// ------------------------------------------------------------------
	class force_scoreboard;
		logic [63:0] cutoff;
		logic [63:0] cap;
		force_t      pending[$];
		int          n_hit, n_miss;

		function new();
			cutoff = CUTOFF_SQ_RESET;
			cap    = FORCE_CAP_RESET;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
			if (idx == CFG_CUTOFF_SQ)
				cutoff = v;
			else if (idx == CFG_FORCE_CAP)
				cap = v;
		endfunction

		// q-format product, truncated, saturating at the magnitude limit
		function logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
			logic [127:0] p;
			p = ({64'd0, a} * {64'd0, b}) >> FB;
			return (p > {64'd0, MAG_LIM}) ? MAG_LIM : p[63:0];
		endfunction

		function logic [63:0] kmul(logic [63:0] a, logic [63:0] k);
			return (a > MAG_LIM / k) ? MAG_LIM : a * k;
		endfunction

		function logic [63:0] root(logic [63:0] n);
			logic [63:0] res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > n)
				b >>= 2;
			while (b != 0) begin
				if (n >= res + b) begin
					n -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res;
		endfunction

		function logic [31:0] clip(logic neg, logic [63:0] mag);
			if (neg) begin
				if (mag > 64'h8000_0000)
					mag = 64'h8000_0000;
				return 32'd0 - mag[31:0];
			end
			return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
		endfunction

		function void note_contact(contact_t c);
			logic signed [32:0] d[3];
			logic [63:0] mag[3];
			logic        neg[3];
			logic [65:0] acc;
			logic [63:0] d2, r, s, s6, t, m, q, g, e, cc;
			logic        fneg, eneg;
			force_t      f;
			d[0] = $signed({c.bx[31], c.bx}) - $signed({c.ax[31], c.ax});
			d[1] = $signed({c.by[31], c.by}) - $signed({c.ay[31], c.ay});
			d[2] = $signed({c.bz[31], c.bz}) - $signed({c.az[31], c.az});
			acc = 0;
			for (int i = 0; i < 3; i++) begin
				neg[i] = d[i] < 0;
				mag[i] = neg[i] ? 64'(-d[i]) : 64'(d[i]);
				acc += {2'b0, mag[i] * mag[i]};
			end
			acc >>= FB;
			if (acc > {2'b0, cutoff}) begin
				f = '{fx: 0, fy: 0, fz: 0, en: 0, hit: 1'b0};
				n_miss++;
			end else begin
				d2 = (acc == 0) ? 64'd1 : acc[63:0];
				r  = root(d2 << FB);
				s  = ({32'd0, c.sig} << FB) / d2;
				s6 = qmul(qmul(s, s), s);
				// energy 4*s6*(s6-1), negative while s6 is below one
				eneg = s6 < ONE_Q;
				e = kmul(qmul(s6, eneg ? ONE_Q - s6 : s6 - ONE_Q), 4);
				// scalar force 24*s6*(1-2*s6)/r
				t = kmul(s6, 2);
				fneg = t >= ONE_Q;
				m = kmul(qmul(s6, fneg ? t - ONE_Q : ONE_Q - t), 24);
				q = m / r;
				if (q > M32)
					q = cap;
				else
					q = (q << FB) + (((m % r) << FB) / r);
				if (q > cap)
					q = cap;
				g = (q << FB) / r;
				cc = qmul(mag[0], g);
				f.fx = clip(neg[0] != fneg && cc != 0, cc);
				cc = qmul(mag[1], g);
				f.fy = clip(neg[1] != fneg && cc != 0, cc);
				cc = qmul(mag[2], g);
				f.fz = clip(neg[2] != fneg && cc != 0, cc);
				f.en = clip(eneg && e != 0, e);
				f.hit = 1'b1;
				n_hit++;
			end
			pending.push_back(f);
		endfunction

		// empty string when the result matches the oldest expectation
		function string check_force(force_t o);
			force_t x;
			string  msg;
			if (pending.size() == 0)
				return "result with nothing expected";
			x = pending.pop_front();
			msg = "";
			if (o.fx !== x.fx)
				msg = {msg, $sformatf(" force_x %h/%h", o.fx, x.fx)};
			if (o.fy !== x.fy)
				msg = {msg, $sformatf(" force_y %h/%h", o.fy, x.fy)};
			if (o.fz !== x.fz)
				msg = {msg, $sformatf(" force_z %h/%h", o.fz, x.fz)};
			if (o.en !== x.en)
				msg = {msg, $sformatf(" pair_energy %h/%h", o.en, x.en)};
			if (o.hit !== x.hit)
				msg = {msg, $sformatf(" in_range %b/%b", o.hit, x.hit)};
			return (msg == "") ? "" : {"mismatch (got/exp):", msg};
		endfunction
	endclass

	logic clk, arst_n;
	logic item_valid, item_stall;
	logic signed [31:0] first_x, first_y, first_z, second_x, second_y, second_z;
	logic [31:0] sig2;
	logic result_valid, result_stall;
	logic signed [31:0] force_x, force_y, force_z, pair_energy;
	logic in_range;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	force_scoreboard contacts_sb;
	int errors;
	int n_results;
	int hold_left;   // long receiver hold, counted down by the stall process
	int n_sent;

	capped_lj_contact_force dut (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic report(string msg);
		errors++;
		$display("[%0t] ERROR: %s", $realtime, msg);
	endtask

	// result monitor: a transaction completes at a rising edge with valid and no stall
	always @(posedge clk) begin
		force_t o;
		string  m;
		if (arst_n && result_valid && !result_stall) begin
			o = '{fx: force_x, fy: force_y, fz: force_z, en: pair_energy, hit: in_range};
			m = contacts_sb.check_force(o);
			n_results++;
			if (m != "")
				report(m);
		end
	end

	// receiver stall pattern: switches between random modes, one of which never stalls
	initial begin
		int mode, cnt;
		result_stall = 1'b0;
		mode = 0;
		cnt = 0;
		forever begin
			@(negedge clk);
			if (cnt == 0) begin
				mode = $urandom_range(0, 3);
				cnt = 64;
			end
			cnt--;
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				case (mode)
				0: result_stall <= 1'b0;
				1: result_stall <= ($urandom_range(0, 3) == 0);
				2: result_stall <= ($urandom_range(0, 3) != 0);
				default: result_stall <= ~result_stall;
				endcase
			end
		end
	end

	// register write, only called with the pipeline empty
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		contacts_sb.set_reg(idx, v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// offer one contact and hold it until the block takes it
	task automatic send_contact(contact_t c);
		@(negedge clk);
		item_valid <= 1'b1;
		first_x  <= c.ax;
		first_y  <= c.ay;
		first_z  <= c.az;
		second_x <= c.bx;
		second_y <= c.by;
		second_z <= c.bz;
		sig2     <= c.sig;
		do
			@(posedge clk);
		while (item_stall);
		contacts_sb.note_contact(c);
		n_sent++;
	endtask

	task automatic idle_input(int n);
		@(negedge clk);
		item_valid <= 1'b0;
		repeat (n - 1)
			@(negedge clk);
	endtask

	// wait for every expected result, then for any trailing pipeline work
	task automatic drain();
		while (contacts_sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	// mostly small separations so contacts land inside the cutoff
	function automatic logic [31:0] pick_delta();
		int span;
		case ($urandom_range(0, 9))
		0: return $urandom;
		1: return 32'd0;
		2: begin
			span = 64;
			return $urandom_range(0, 2 * span) - span;
		end
		default: begin
			span = $urandom_range(1, 20) << FB;
			return $urandom_range(0, 2 * span) - span;
		end
		endcase
	endfunction

	function automatic logic [31:0] pick_sigma();
		case ($urandom_range(0, 9))
		0: return $urandom;
		1: return $urandom_range(0, 255);
		default: return $urandom_range(1 << 13, 40 << FB);
		endcase
	endfunction

	function automatic contact_t rand_contact();
		contact_t c;
		c.ax = $urandom;
		c.ay = $urandom;
		c.az = $urandom;
		c.bx = c.ax + pick_delta();
		c.by = c.ay + pick_delta();
		c.bz = c.az + pick_delta();
		c.sig = pick_sigma();
		return c;
	endfunction

	function automatic contact_t mk(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
			logic [31:0] dx, logic [31:0] dy, logic [31:0] dz, logic [31:0] sg);
		contact_t c;
		c = '{ax: ax, ay: ay, az: az, bx: ax + dx, by: ay + dy, bz: az + dz, sig: sg};
		return c;
	endfunction

	task automatic directed_set();
		contact_t d[$];
		d.push_back(mk(0, 0, 0, 0, 0, 0, 32'h0001_0000));          // coincident atoms
		d.push_back(mk(0, 0, 0, 0, 0, 0, 0));
		d.push_back(mk(0, 0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000)); // at sigma
		d.push_back(mk(0, 0, 0, 32'h0000_E000, 0, 0, 32'h0001_0000)); // repulsive
		d.push_back(mk(0, 0, 0, 0, 32'h0001_8000, 0, 32'h0001_0000)); // attractive
		d.push_back(mk(5, 7, 9, 0, 0, 32'h0000_0100, 32'hFFFF_FFFF)); // huge overlap
		d.push_back(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0001, 32'h8000_0001, 32'h8000_0001, 32'hFFFF_FFFF));
		d.push_back(mk(32'h8000_0000, 0, 0, 32'hFFFF_FFFF, 0, 0, 32'h0001_0000)); // wide span
		d.push_back(mk(0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0012_0000, 0, 0,
			32'h0004_0000));                                          // on the cutoff
		d.push_back(mk(0, 0, 0, 32'h0012_0001, 0, 0, 32'h0004_0000)); // just outside
		d.push_back(mk(0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'h0000_0001));
		d.push_back(mk(32'h1234_5678, 32'hFEDC_BA98, 32'h0F0F_0F0F,
			32'hFFF0_0000, 32'h0010_0000, 32'hFFFF_8000, 32'h0009_0000));
		foreach (d[i])
			send_contact(d[i]);
		idle_input(1);
	endtask

	task automatic random_set(int count, bit long_hold);
		int burst;
		burst = 0;
		for (int i = 0; i < count; i++) begin
			// long receiver hold while contacts keep coming, fills the pipeline
			if (long_hold && i == count / 3)
				hold_left = 600;
			if (burst == 0) begin
				if ($urandom_range(0, 2) != 0)
					idle_input($urandom_range(1, 8));
				burst = $urandom_range(1, 40);
			end
			burst--;
			send_contact(rand_contact());
		end
		idle_input(1);
	endtask

	initial begin
		errors = 0;
		n_results = 0;
		n_sent = 0;
		hold_left = 0;
		contacts_sb = new();
		arst_n = 1'b0;
		item_valid = 1'b0;
		first_x = 0;
		first_y = 0;
		first_z = 0;
		second_x = 0;
		second_y = 0;
		second_z = 0;
		sig2 = 0;
		cfg_valid = 1'b0;
		cfg_index = CFG_CUTOFF_SQ;
		cfg_data = 0;
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset defaults
		directed_set();
		random_set(280, 1'b1);
		drain();   // sender pauses until every result is back

		// widest cutoff, no cap; spare indexes must be ignored
		write_reg(CFG_CUTOFF_SQ, 32'hFFFF_FFFF);
		write_reg(CFG_SPARE_A, 32'h0000_0000);
		directed_set();
		random_set(260, 1'b0);
		drain();

		// zero cutoff and zero cap
		write_reg(CFG_CUTOFF_SQ, 32'h0000_0000);
		write_reg(CFG_FORCE_CAP, 32'h0000_0000);
		write_reg(CFG_SPARE_B, 32'h1234_5678);
		directed_set();
		random_set(200, 1'b0);
		drain();

		// moderate cap
		write_reg(CFG_CUTOFF_SQ, 32'h0190_0000);
		write_reg(CFG_FORCE_CAP, 32'h0010_0000);
		random_set(260, 1'b1);
		drain();

		// random register values
		for (int p = 0; p < 3; p++) begin
			write_reg(CFG_CUTOFF_SQ, $urandom_range(1 << FB, 32'h0400_0000));
			write_reg(CFG_FORCE_CAP, $urandom);
			random_set(150, p == 1);
			drain();
		end

		$display("contacts sent: %0d, results checked: %0d (%0d in range, %0d skipped)",
			n_sent, n_results, contacts_sb.n_hit, contacts_sb.n_miss);
		$display("register settings covered: defaults, both extremes, fixed and random caps");
		if (errors == 0) begin
			$display("capped_lj_contact_force_tb OK");
		end else begin
			$display("%0d errors", errors);
			$display("capped_lj_contact_force_tb NOT OK");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("timeout, %0d results still expected", contacts_sb.pending.size());
		$display("capped_lj_contact_force_tb NOT OK");
		$finish;
	end

endmodule
